### rtl/breakpoint_table_linear_interpolator_macros.svh
// Assertion macros shared by the breakpoint interpolator RTL.
`ifndef BREAKPOINT_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define BPI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define BPI_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BPI_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/bpi_pkg.sv
// Types and constants shared by the breakpoint interpolator modules.
`timescale 1ns / 1ps
`default_nettype none

package bpi_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int STEP_W     = $clog2(FRAC_BITS);
   // Signed fraction (FRAC_BITS + 1) times signed value difference (VALUE_BITS + 1).
   localparam int PROD_W     = FRAC_BITS + VALUE_BITS + 2;
   localparam int REQ_DATA_W = KEY_BITS + VALUE_BITS;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_EVAL   = 2'd2,
      CMD_IGNORE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_PROBE,
      S_COMPARE,
      S_UPPER,
      S_LOWER,
      S_DIVIDE,
      S_MULTIPLY,
      S_ACCUM,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      ADDR_MID,
      ADDR_LO,
      ADDR_LO_PREV
   } addr_sel_type;

   typedef enum logic [2:0] {
      RES_OK_ZERO,
      RES_RANGE,
      RES_REJECT,
      RES_HIT,
      RES_INTERP
   } res_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         clear_tbl;
      logic         write_entry;
      logic         search_init;
      logic         search_step;
      logic         save_upper;
      logic         div_init;
      logic         div_step;
      logic         mul_load;
      logic         set_result;
      res_sel_type  res_sel;
      addr_sel_type addr_sel;
      logic         out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    append_ok;
      logic    table_empty;
      logic    search_more;
      logic    key_hit;
      logic    bracket_ok;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/bpi_dpath.sv
// Datapath: breakpoint memories, binary search, divider, multiplier, result registers.
`timescale 1ns / 1ps
`default_nettype none

module bpi_dpath #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [bpi_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]                 req_tuser,
   input  wire bpi_pkg::ctrl_cmd_type      cmd,
   output      bpi_pkg::dp_status_type     sts,
   output      logic [bpi_pkg::VALUE_BITS-1:0] rsp_tdata,
   output      logic [1:0]                 rsp_tuser
);
   import bpi_pkg::*;

   `include "breakpoint_table_linear_interpolator_macros.svh"

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;

   cmd_type               cmd_code_ff, cmd_code_in;
   logic [KEY_BITS-1:0]   x_ff, x_in;
   logic [VALUE_BITS-1:0] pv_ff, pv_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [KEY_BITS-1:0]   last_key_ff, last_key_in;
   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic [KEY_BITS-1:0]   xu_ff, xu_in;
   logic [VALUE_BITS-1:0] yu_ff, yu_in;
   logic [VALUE_BITS-1:0] yl_ff, yl_in;
   logic [KEY_BITS-1:0]   rem_ff, rem_in;
   logic [KEY_BITS-1:0]   den_ff, den_in;
   logic [FRAC_BITS-1:0]  quo_ff, quo_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [VALUE_BITS-1:0] res_ff, res_in;
   status_type            res_st_ff, res_st_in;
   logic [VALUE_BITS-1:0] out_data_ff, out_data_in;
   status_type            out_st_ff, out_st_in;

   logic [CNT_W-1:0]      mid;
   logic [CNT_W-1:0]      lo_prev;
   logic [ADDR_W-1:0]     rd_addr;
   logic [KEY_BITS:0]     rem_shift;
   logic [KEY_BITS:0]     den_ext;
   logic                  rem_ge;
   logic [KEY_BITS:0]     rem_sub;
   logic signed [VALUE_BITS:0] y_diff;
   logic signed [PROD_W-1:0] frac_wide;
   logic signed [PROD_W-1:0] diff_wide;
   logic [VALUE_BITS-1:0] interp;

   // Search midpoint and read address.
   always_comb begin
      mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
      lo_prev = lo_ff - CNT_W'(1);
      case (cmd.addr_sel)
         ADDR_MID:     rd_addr = mid[ADDR_W-1:0];
         ADDR_LO:      rd_addr = lo_ff[ADDR_W-1:0];
         ADDR_LO_PREV: rd_addr = lo_prev[ADDR_W-1:0];
         default:      rd_addr = mid[ADDR_W-1:0];
      endcase
   end

   // One restoring division step and the interpolation arithmetic.
   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      den_ext   = {1'b0, den_ff};
      rem_ge    = (rem_shift >= den_ext);
      rem_sub   = rem_shift - den_ext;
      y_diff    = $signed({yu_ff[VALUE_BITS-1], yu_ff}) - $signed({yl_ff[VALUE_BITS-1], yl_ff});
      // Both factors are sign-extended to the product width; only the low
      // FRAC_BITS + 1 and VALUE_BITS + 1 bits carry information.
      frac_wide = PROD_W'($signed({1'b0, quo_ff}));
      diff_wide = PROD_W'(y_diff);
      interp    = yl_ff + prod_ff[FRAC_BITS +: VALUE_BITS];
   end

   always_comb begin
      sts.cmd         = cmd_code_ff;
      sts.append_ok   = (count_ff < CNT_W'(TABLE_DEPTH)) &&
                        ((count_ff == '0) || (x_ff > last_key_ff));
      sts.table_empty = (count_ff == '0);
      sts.search_more = (lo_ff < hi_ff);
      sts.key_hit     = (lo_ff < count_ff) && (key_rd_ff == x_ff);
      sts.bracket_ok  = (lo_ff != '0) && (lo_ff < count_ff);
   end

   always_comb begin
      cmd_code_in = cmd_code_ff;
      x_in        = x_ff;
      pv_in       = pv_ff;
      count_in    = count_ff;
      last_key_in = last_key_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      xu_in       = xu_ff;
      yu_in       = yu_ff;
      yl_in       = yl_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      quo_in      = quo_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      res_st_in   = res_st_ff;
      out_data_in = out_data_ff;
      out_st_in   = out_st_ff;

      if (cmd.load_req) begin
         cmd_code_in = cmd_type'(req_tuser);
         x_in        = req_tdata[KEY_BITS-1:0];
         pv_in       = req_tdata[KEY_BITS +: VALUE_BITS];
      end
      if (cmd.clear_tbl) begin
         count_in = '0;
      end
      if (cmd.write_entry) begin
         count_in    = count_ff + CNT_W'(1);
         last_key_in = x_ff;
      end
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.search_step) begin
         if (key_rd_ff < x_ff) begin
            lo_in = mid + CNT_W'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.save_upper) begin
         xu_in = key_rd_ff;
         yu_in = val_rd_ff;
      end
      if (cmd.div_init) begin
         // The read data holds the lower breakpoint here.
         yl_in  = val_rd_ff;
         rem_in = x_ff - key_rd_ff;
         den_in = xu_ff - key_rd_ff;
         quo_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_sub[KEY_BITS-1:0] : rem_shift[KEY_BITS-1:0];
         quo_in = {quo_ff[FRAC_BITS-2:0], rem_ge};
      end
      if (cmd.mul_load) begin
         prod_in = frac_wide * diff_wide;
      end
      if (cmd.set_result) begin
         case (cmd.res_sel)
            RES_OK_ZERO: begin res_in = '0;        res_st_in = ST_OK;     end
            RES_RANGE:   begin res_in = '0;        res_st_in = ST_RANGE;  end
            RES_REJECT:  begin res_in = '0;        res_st_in = ST_REJECT; end
            RES_HIT:     begin res_in = val_rd_ff; res_st_in = ST_OK;     end
            RES_INTERP:  begin res_in = interp;    res_st_in = ST_OK;     end
            default:     begin res_in = '0;        res_st_in = ST_OK;     end
         endcase
      end
      if (cmd.out_load) begin
         out_data_in = res_ff;
         out_st_in   = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_code_ff <= cmd_code_in;
      x_ff        <= x_in;
      pv_ff       <= pv_in;
      last_key_ff <= last_key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      xu_ff       <= xu_in;
      yu_ff       <= yu_in;
      yl_ff       <= yl_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      res_st_ff   <= res_st_in;
      out_data_ff <= out_data_in;
      out_st_ff   <= out_st_in;
   end

   // Breakpoint memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         key_mem[count_ff[ADDR_W-1:0]] <= x_ff;
         val_mem[count_ff[ADDR_W-1:0]] <= pv_ff;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_st_ff;

   `BPI_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `BPI_ASSERT_IMPL(a_probe_open, clock, reset, cmd.search_step, lo_ff < hi_ff)
   `BPI_ASSERT_NEXT(a_write_grows, clock, reset, cmd.write_entry, count_ff != '0)

endmodule

`default_nettype wire

### rtl/bpi_ctrl.sv
// Controller state machine sequencing clear, append and evaluate requests.
`timescale 1ns / 1ps
`default_nettype none

module bpi_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire bpi_pkg::dp_status_type sts,
   output      bpi_pkg::ctrl_cmd_type  cmd
);
   import bpi_pkg::*;

   `include "breakpoint_table_linear_interpolator_macros.svh"

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.cmd == CMD_EVAL && !sts.table_empty) begin
               state_in = S_PROBE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PROBE: begin
            state_in = sts.search_more ? S_COMPARE : S_UPPER;
         end
         S_COMPARE: state_in = S_PROBE;
         S_UPPER: begin
            if (sts.key_hit || !sts.bracket_ok) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_LOWER;
            end
         end
         S_LOWER: state_in = S_DIVIDE;
         S_DIVIDE: begin
            if (step_ff == STEP_W'(FRAC_BITS - 1)) begin
               state_in = S_MULTIPLY;
            end
         end
         S_MULTIPLY: state_in = S_ACCUM;
         S_ACCUM:    state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd          = '0;
      cmd.res_sel  = RES_OK_ZERO;
      cmd.addr_sel = ADDR_MID;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_DECODE: begin
            cmd.set_result = 1'b1;
            case (sts.cmd)
               CMD_CLEAR: begin
                  cmd.clear_tbl = 1'b1;
               end
               CMD_APPEND: begin
                  if (sts.append_ok) begin
                     cmd.write_entry = 1'b1;
                  end else begin
                     cmd.res_sel = RES_REJECT;
                  end
               end
               CMD_EVAL: begin
                  if (sts.table_empty) begin
                     cmd.res_sel = RES_RANGE;
                  end else begin
                     cmd.set_result  = 1'b0;
                     cmd.search_init = 1'b1;
                  end
               end
               default: cmd.res_sel = RES_OK_ZERO;
            endcase
         end
         S_PROBE: begin
            cmd.addr_sel = sts.search_more ? ADDR_MID : ADDR_LO;
         end
         S_COMPARE: begin
            cmd.search_step = 1'b1;
         end
         S_UPPER: begin
            cmd.addr_sel = ADDR_LO_PREV;
            if (sts.key_hit) begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_HIT;
            end else if (!sts.bracket_ok) begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_RANGE;
            end else begin
               cmd.save_upper = 1'b1;
            end
         end
         S_LOWER:    cmd.div_init = 1'b1;
         S_DIVIDE:   cmd.div_step = 1'b1;
         S_MULTIPLY: cmd.mul_load = 1'b1;
         S_ACCUM: begin
            cmd.set_result = 1'b1;
            cmd.res_sel    = RES_INTERP;
         end
         S_FINISH: begin
            cmd.out_load = out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (state_ff == S_LOWER) begin
         step_in = '0;
      end else if (state_ff == S_DIVIDE) begin
         step_in = step_ff + STEP_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `BPI_ASSERT_NEXT(a_accept_decodes, clock, reset, req_tvalid && req_tready, state_ff == S_DECODE)
   `BPI_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid_ff)
   `BPI_ASSERT_NEXT(a_div_count, clock, reset, state_ff == S_LOWER, step_ff == '0)

endmodule

`default_nettype wire

### rtl/breakpoint_table_linear_interpolator.sv
// Top level of the breakpoint table with piecewise linear interpolation.
`timescale 1ns / 1ps
`default_nettype none

// This block keeps a table of up to TABLE_DEPTH breakpoints, each a 32-bit
// unsigned frequency key with a signed Q16.16 value, and answers one response
// per request. A clear request empties the table; an append request adds one
// breakpoint at the end and is rejected (status 2) when the table is full or
// the key does not strictly ascend; an evaluate request finds the bracketing
// breakpoints by binary search, returns the stored value on an exact key hit,
// and otherwise returns y_l + floor(f * (y_u - y_l)), with f the 16-bit
// truncated fraction (x - x_l) / (x_u - x_l). Evaluating an empty table or a
// frequency outside the first and last keys gives status 1 and a zero value.
// Requests are handled one at a time. A clear, an append or an unused command
// is decoded in the cycle after acceptance; its result is registered while it
// is decoded and then loaded into the output register from the finish state,
// after which the controller returns to idle to take the next request. An
// evaluate request runs a binary search over the n stored entries, in which
// each probe reads the single read port of the breakpoint memory and compares
// in the next cycle; then one state reads the entry at the final bound and one
// reads its lower neighbor, followed by the one-bit-per-cycle restoring
// divider, a multiply state and an accumulate state. An exact hit or an
// out-of-range query ends after the final bound is read, without dividing.
// The response sits in an output register, so a new request is accepted while
// the previous response still waits to be taken; a finished request whose
// response finds that register still occupied holds in its last cycle until
// the waiting response is taken. No clearing pass follows reset: entries at
// or above the entry count may be read but are never used.

module breakpoint_table_linear_interpolator #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   // Fields from bit 0 up: frequency [31:0], point_value [63:32].
   input  wire logic [bpi_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: command [1:0].
   input  wire logic [1:0]                     req_tuser,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // Fields from bit 0 up: result_value [31:0].
   output      logic [bpi_pkg::VALUE_BITS-1:0] rsp_tdata,
   // Fields from bit 0 up: status [1:0].
   output      logic [1:0]                     rsp_tuser
);
   import bpi_pkg::*;

   // Commands from the controller and status back from the datapath.
   ctrl_cmd_type  cmd;
   dp_status_type sts;

   bpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the breakpoint memories, the search bounds, the
   // divider and multiplier, and the response payload register.
   bpi_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire
